// ----- rtl/lzss_pkg.sv -----
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared constants and the command word passed from the parser to the
// copy engine of the LZSS stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzss_pkg;

  // Window and token format
  localparam int WINDOW_SIZE_DEF = 4096;
  localparam int RING_W          = 12;
  localparam int LEN_W           = 5;
  localparam int LOOKAHEAD       = 18;
  localparam int MIN_COPY        = 3;

  // File header: size bytes first, then ignored bytes
  localparam int HEADER_BYTES    = 8;
  localparam int SIZE_BYTES      = 4;

  // Command queue depth between parser and copy engine
  localparam int CMD_DEPTH       = 2;

  // One command: a literal byte or a window copy
  typedef struct packed {
    logic              is_copy;
    logic [RING_W-1:0] ring;
    logic [LEN_W-1:0]  len;
    logic [7:0]        lit;
    logic              eof;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/lzss_ram.sv -----
// ----------------------------------------------------------------------------
// lzss_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lzss_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// lzss_cmd_fifo
// Short command queue that decouples the parser from the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_cmd_fifo
  import lzss_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Occupancy never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("command queue overflow");

  // A full queue never takes a push without a pop
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("push into full command queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/lzss_front.sv -----
// ----------------------------------------------------------------------------
// lzss_front
// Parser: takes header, flag bytes and tokens, tracks the bytes still owed
// and issues literal and copy commands, with copies cut at the file end.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_front
  import lzss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_t            q_cmd
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_TOKEN  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  phase_t       phase;
  logic [2:0]   hcount;
  logic [31:0]  remaining;
  logic [7:0]   flags;
  logic [3:0]   bits_left;
  logic [7:0]   token_low;

  logic             accept;
  logic [LEN_W-1:0] tok_len;
  logic             tok_cut;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Decode the token length and check it against the bytes still owed
  assign tok_len = LEN_W'(in_byte[3:0]) + LEN_W'(MIN_COPY);
  assign tok_cut = ({{(32-LEN_W){1'b0}}, tok_len} >= remaining);

  // Build the command for the current word
  always_comb begin
    q_push         = 1'b0;
    q_cmd.is_copy  = 1'b0;
    q_cmd.ring     = {in_byte[7:4], token_low};
    q_cmd.len      = tok_len;
    q_cmd.lit      = in_byte;
    q_cmd.eof      = 1'b0;
    unique case (phase)
      PH_DATA: begin
        if (accept && bits_left != 4'd0 && flags[0]) begin
          q_push    = 1'b1;
          q_cmd.eof = (remaining == 32'd1);
        end
      end
      PH_TOKEN: begin
        q_push        = accept;
        q_cmd.is_copy = 1'b1;
        if (tok_cut) begin
          q_cmd.len = remaining[LEN_W-1:0];
          q_cmd.eof = 1'b1;
        end
      end
      PH_HEADER, PH_DONE: begin
        q_push = 1'b0;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // Advance the parse state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hcount    <= '0;
      remaining <= '0;
      flags     <= '0;
      bits_left <= '0;
      token_low <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (hcount < 3'(SIZE_BYTES)) begin
            remaining[{hcount[1:0], 3'b000} +: 8] <= in_byte;
          end
          hcount <= hcount + 1'b1;
          if (hcount == 3'(HEADER_BYTES - 1)) begin
            bits_left <= '0;
            phase     <= (remaining == 32'd0) ? PH_DONE : PH_DATA;
          end
        end
        PH_DATA: begin
          if (bits_left == 4'd0) begin
            flags     <= in_byte;
            bits_left <= 4'd8;
          end else begin
            if (flags[0]) begin
              remaining <= remaining - 32'd1;
              if (remaining == 32'd1) begin
                phase <= PH_DONE;
              end
            end else begin
              token_low <= in_byte;
              phase     <= PH_TOKEN;
            end
            flags     <= {1'b0, flags[7:1]};
            bits_left <= bits_left - 4'd1;
          end
        end
        PH_TOKEN: begin
          if (tok_cut) begin
            remaining <= '0;
            phase     <= PH_DONE;
          end else begin
            remaining <= remaining - {{(32-LEN_W){1'b0}}, tok_len};
            phase     <= PH_DATA;
          end
        end
        PH_DONE: begin
          phase <= PH_DONE;
        end
        default: begin
          phase <= PH_DONE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A command marked as file end always leaves the parser done
  a_eof_done: assert property (@(posedge clk) disable iff (rst)
    q_push && q_cmd.eof |=> phase == PH_DONE)
    else $error("file end issued without reaching done");

  // Once done, no further commands are issued
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> !q_push)
    else $error("command issued after file end");
`endif

endmodule

`default_nettype wire

// ----- rtl/lzss_back.sv -----
// ----------------------------------------------------------------------------
// lzss_back
// Copy engine: executes literal and copy commands against the sliding
// window and drives the registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_back
  import lzss_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  cmd_t            q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            end_of_file
);

  localparam int AW = $clog2(WINDOW_SIZE);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_READ  = 3'b010,
    B_WRITE = 3'b100
  } bstate_t;

  bstate_t          state;
  logic [AW-1:0]    ring;
  logic [LEN_W-1:0] len_left;
  logic             cmd_eof;
  logic             zero_rd;
  logic [AW-1:0]    wlow;
  logic             full;

  logic             out_free;
  logic             load;
  logic [7:0]       load_byte;
  logic             load_last;
  logic             load_eof;
  logic             we;
  logic [7:0]       wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;
  logic             raddr_zero;

  assign out_free = !out_valid || out_ready;

  // A source not yet written reads as zero until the window has filled
  assign raddr_zero = !full && ((raddr + AW'(LOOKAHEAD)) >= wlow);

  // Sequence the window reads and writes
  always_comb begin
    q_pop     = 1'b0;
    load      = 1'b0;
    load_byte = q_head.lit;
    load_last = 1'b1;
    load_eof  = q_head.eof;
    we        = 1'b0;
    wdata     = q_head.lit;
    re        = 1'b0;
    raddr     = ring;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.is_copy) begin
            re    = 1'b1;
            raddr = AW'(q_head.ring);
          end else begin
            we   = 1'b1;
            load = 1'b1;
          end
        end
      end
      B_READ: begin
        re = 1'b1;
      end
      B_WRITE: begin
        if (out_free) begin
          wdata     = zero_rd ? 8'd0 : rdata;
          we        = 1'b1;
          load      = 1'b1;
          load_byte = wdata;
          load_last = (len_left == LEN_W'(1));
          load_eof  = cmd_eof && (len_left == LEN_W'(1));
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Advance the engine state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      len_left <= '0;
      cmd_eof  <= 1'b0;
      ring     <= '0;
      zero_rd  <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (q_pop && q_head.is_copy) begin
            ring     <= AW'(q_head.ring) + 1'b1;
            len_left <= q_head.len;
            cmd_eof  <= q_head.eof;
            zero_rd  <= raddr_zero;
            state    <= B_WRITE;
          end
        end
        B_READ: begin
          ring    <= ring + 1'b1;
          zero_rd <= raddr_zero;
          state   <= B_WRITE;
        end
        B_WRITE: begin
          if (load) begin
            len_left <= len_left - 1'b1;
            state    <= (len_left == LEN_W'(1)) ? B_IDLE : B_READ;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // Track the output position and whether the window has filled
  always_ff @(posedge clk) begin
    if (rst) begin
      wlow <= '0;
      full <= 1'b0;
    end else if (we) begin
      wlow <= wlow + 1'b1;
      if (wlow == {AW{1'b1}}) begin
        full <= 1'b1;
      end
    end
  end

  // Hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= load_byte;
      last_of_run <= load_last;
      end_of_file <= load_eof;
    end
  end

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (we),
    .waddr (wlow - AW'(LOOKAHEAD)),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

`ifndef SYNTHESIS
  // The file end word always closes its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_file |-> last_of_run)
    else $error("file end without end of run");

  // Every window read is followed by its write stage
  a_read_write: assert property (@(posedge clk) disable iff (rst)
    state == B_READ |=> state == B_WRITE)
    else $error("read stage not followed by write stage");

  // Window writes happen only together with an output load
  a_write_load: assert property (@(posedge clk) disable iff (rst)
    we |-> load)
    else $error("window write without output word");
`endif

endmodule

`default_nettype wire

// ----- rtl/lzss_stream_decompressor.sv -----
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decompressor with a 4096-byte sliding window, byte stream in and out.
// ----------------------------------------------------------------------------
// Feed the compressed file one byte per word, 8-byte header first (32-bit
// little-endian output size, then four ignored bytes). Header, flag and
// token-low bytes give no output. A literal byte yields one output word,
// registered in the cycle after its command leaves the internal two-entry
// command queue. In the copy engine each byte of a copy needs a registered
// read of the window RAM and then a write-back of the same byte, since a
// copy may overlap its own output. The input keeps flowing while the queue
// has room, so parsing overlaps copying. last_of_run marks the final word
// caused by an input byte; end_of_file marks the word that reaches the
// declared size, after which input is taken and dropped until reset.
// Window positions not yet written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_stream_decompressor
  import lzss_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic            end_of_file
);

  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  lzss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  lzss_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  lzss_back #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .end_of_file (end_of_file)
  );

endmodule

`default_nettype wire
